>>> sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg: shared definitions of the six wheel skid steer mixer
// Register map, drive modes, wheel order tables and default parameters.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int FRAC_BITS_DEF   = 12;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int CFG_W      = 15;

	localparam int NUM_WHEELS = 6;
	localparam int WHEEL_W    = 3;

	localparam logic [1:0] REG_DRIVE_MODE     = 2'd0;
	localparam logic [1:0] REG_MIDDLE_OFFSET  = 2'd1;
	localparam logic [1:0] REG_STANDING_SPEED = 2'd2;
	localparam logic [1:0] REG_FRONT_BOOST    = 2'd3;

	localparam logic signed [CFG_W-1:0] MIDDLE_OFFSET_RST  = 15'sd410;
	localparam logic signed [CFG_W-1:0] STANDING_SPEED_RST = 15'sd819;
	localparam logic signed [CFG_W-1:0] FRONT_BOOST_RST    = 15'sd1229;

	typedef enum logic [2:0] {
		MODE_NORMAL      = 3'd0,
		MODE_BOGIE_DRIVE = 3'd1,
		MODE_BOGIE_STAND = 3'd2,
		MODE_CLIMB       = 3'd3,
		MODE_BOGIE_BOOST = 3'd4
	} smx_mode_t;

	localparam logic [1:0] ROW_FRONT  = 2'd0;
	localparam logic [1:0] ROW_MIDDLE = 2'd1;
	localparam logic [1:0] ROW_REAR   = 2'd2;

	localparam logic [WHEEL_W-1:0] WHEEL_LAST = 3'd5;
	localparam logic [WHEEL_W-1:0] WHEEL_FIRST_RIGHT = 3'd3;

	// Wheel order: left front, middle, rear, then right front, middle, rear.
	localparam logic [5:0] NODE_IDS [NUM_WHEELS] =
		'{6'h11, 6'h21, 6'h31, 6'h12, 6'h22, 6'h32};
	localparam logic [1:0] WHEEL_ROWS [NUM_WHEELS] =
		'{ROW_FRONT, ROW_MIDDLE, ROW_REAR, ROW_FRONT, ROW_MIDDLE, ROW_REAR};

	localparam int POWER_W       = 11;
	localparam int POWER_POS_LIM = 1023;
	localparam int POWER_NEG_LIM = 1024;

	typedef struct packed {
		logic [2:0]              drive_mode;
		logic signed [CFG_W-1:0] middle_drive_offset;
		logic signed [CFG_W-1:0] bogie_standing_speed;
		logic signed [CFG_W-1:0] front_boost;
	} smx_cfg_t;

endpackage

>>> sv/smx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_if: channel interfaces of the mixer
// Velocity command channel in, wheel command channel out.
// ----------------------------------------------------------------------------
interface smx_vel_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] linear_speed;
	logic signed [15:0] angular_speed;

	modport source (output valid, linear_speed, angular_speed, input ready);
	modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

interface smx_whl_if;
	logic               valid;
	logic               ready;
	logic [5:0]         node_id;
	logic signed [10:0] wheel_power;
	logic               brake;
	logic               last;

	modport source (output valid, node_id, wheel_power, brake, last, input ready);
	modport sink (input valid, node_id, wheel_power, brake, last, output ready);
endinterface

>>> sv/smx_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_regs: configuration register file
// APB write and read access to the drive mode and the three Q-format offsets.
// ----------------------------------------------------------------------------
module smx_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [smx_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [smx_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [smx_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output smx_pkg::smx_cfg_t               cfg
);
	import smx_pkg::*;

	smx_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode           <= MODE_NORMAL;
			cfg_q.middle_drive_offset  <= MIDDLE_OFFSET_RST;
			cfg_q.bogie_standing_speed <= STANDING_SPEED_RST;
			cfg_q.front_boost          <= FRONT_BOOST_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DRIVE_MODE:     cfg_q.drive_mode           <= pwdata[2:0];
				REG_MIDDLE_OFFSET:  cfg_q.middle_drive_offset  <= pwdata[CFG_W-1:0];
				REG_STANDING_SPEED: cfg_q.bogie_standing_speed <= pwdata[CFG_W-1:0];
				REG_FRONT_BOOST:    cfg_q.front_boost          <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DRIVE_MODE:     prdata = APB_DATA_W'(cfg_q.drive_mode);
			REG_MIDDLE_OFFSET:  prdata = APB_DATA_W'(cfg_q.middle_drive_offset);
			REG_STANDING_SPEED: prdata = APB_DATA_W'(cfg_q.bogie_standing_speed);
			REG_FRONT_BOOST:    prdata = APB_DATA_W'(cfg_q.front_boost);
			default:            prdata = '0;
		endcase
	end

endmodule

>>> sv/smx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_front: command intake
// Forms the saturated left and right side values and the opposite sign flag.
// ----------------------------------------------------------------------------
module smx_front #(
	parameter int FRAC_BITS = smx_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = FRAC_BITS + 2
) (
	smx_vel_if.sink             cmd,
	output logic                wr_valid,
	input  logic                wr_ready,
	output logic [2*SIDE_W:0]   wr_data
);
	import smx_pkg::*;

	localparam int SumW = 17;
	localparam logic signed [SumW-1:0] PosOne = SumW'(1 << FRAC_BITS);
	localparam logic signed [SumW-1:0] NegOne = -PosOne;

	logic signed [SumW-1:0]   diff;
	logic signed [SumW-1:0]   sum;
	logic signed [SIDE_W-1:0] left;
	logic signed [SIDE_W-1:0] right;
	logic                     mid_off;

	function automatic logic signed [SIDE_W-1:0] sat_one(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] c;
		begin
			if (v > PosOne) begin
				c = PosOne;
			end else if (v < NegOne) begin
				c = NegOne;
			end else begin
				c = v;
			end
			return SIDE_W'(c);
		end
	endfunction

	assign diff  = SumW'(cmd.linear_speed) - SumW'(cmd.angular_speed);
	assign sum   = SumW'(cmd.linear_speed) + SumW'(cmd.angular_speed);
	assign left  = sat_one(diff);
	assign right = sat_one(sum);

	// The middle wheels are idled when the two sides turn in opposite directions.
	assign mid_off = (left > 0 && right < 0) || (left < 0 && right > 0);

	assign wr_valid  = cmd.valid;
	assign cmd.ready = wr_ready;
	assign wr_data   = {mid_off, left, right};

endmodule

>>> sv/smx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_queue: small command queue
// Register-based FIFO that decouples the intake from the wheel sequencer.
// ----------------------------------------------------------------------------
module smx_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = smx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_pop,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CntFull);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/smx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_back: wheel sequencer
// Walks the six wheels of a queued command, applies the drive mode in the
// first stage and scales to power in the output stage.
// ----------------------------------------------------------------------------
module smx_back #(
	parameter int FRAC_BITS = smx_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = FRAC_BITS + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smx_pkg::smx_cfg_t   cfg,
	input  logic                q_valid,
	input  logic [2*SIDE_W:0]   q_data,
	output logic                q_pop,
	smx_whl_if.source           wheel
);
	import smx_pkg::*;

	localparam int ValW  = ((SIDE_W > CFG_W) ? SIDE_W : CFG_W) + 1;
	localparam int ProdW = ValW + 8;

	logic                     adv;
	logic                     s1_en;
	logic                     issue;
	logic [WHEEL_W-1:0]       wheel_q;

	logic                     q_mid_off;
	logic signed [SIDE_W-1:0] q_left;
	logic signed [SIDE_W-1:0] q_right;
	logic signed [ValW-1:0]   side_v;
	logic signed [ValW-1:0]   front_v;
	logic signed [ValW-1:0]   middle_v;
	logic signed [ValW-1:0]   rear_v;
	logic signed [ValW-1:0]   wheel_v;

	logic                     valid_s1;
	logic signed [ValW-1:0]   val_s1;
	logic [WHEEL_W-1:0]       wheel_s1;

	logic                     neg;
	logic [ValW-1:0]          mag;
	logic [ProdW-1:0]         prod;
	logic [ProdW-1:0]         scaled;
	logic signed [POWER_W-1:0] power_c;

	logic                     out_valid_q;
	logic [5:0]               node_id_q;
	logic signed [POWER_W-1:0] power_q;
	logic                     brake_q;
	logic                     last_q;

	assign {q_mid_off, q_left, q_right} = q_data;

	// The output register takes a new result when empty or when its transfer completes.
	assign adv   = !out_valid_q || wheel.ready;
	assign s1_en = !valid_s1 || adv;
	assign issue = q_valid && s1_en;
	assign q_pop = issue && (wheel_q == WHEEL_LAST);

	always_comb begin
		side_v = (wheel_q >= WHEEL_FIRST_RIGHT) ? ValW'(q_right) : ValW'(q_left);
		front_v  = '0;
		middle_v = '0;
		rear_v   = '0;
		case (cfg.drive_mode)
			MODE_NORMAL: begin
				front_v  = side_v;
				middle_v = side_v;
				rear_v   = side_v;
			end
			MODE_BOGIE_DRIVE: begin
				front_v  = side_v;
				middle_v = side_v + ValW'(cfg.middle_drive_offset);
				rear_v   = side_v;
			end
			MODE_BOGIE_STAND: begin
				front_v  = side_v;
				middle_v = side_v + ValW'(cfg.bogie_standing_speed);
				rear_v   = -ValW'(cfg.bogie_standing_speed);
			end
			MODE_CLIMB: begin
				front_v  = side_v + ValW'(cfg.front_boost);
				middle_v = side_v;
				rear_v   = side_v;
			end
			MODE_BOGIE_BOOST: begin
				front_v  = side_v + ValW'(cfg.front_boost);
				middle_v = side_v + ValW'(cfg.bogie_standing_speed);
				rear_v   = -ValW'(cfg.bogie_standing_speed);
			end
			default: ;
		endcase
		if (q_mid_off) begin
			middle_v = '0;
		end
		case (WHEEL_ROWS[wheel_q])
			ROW_FRONT:  wheel_v = front_v;
			ROW_MIDDLE: wheel_v = middle_v;
			ROW_REAR:   wheel_v = rear_v;
			default:    wheel_v = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				wheel_q <= (wheel_q == WHEEL_LAST) ? '0 : wheel_q + 1'b1;
			end
			if (s1_en) begin
				valid_s1 <= issue;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			val_s1   <= wheel_v;
			wheel_s1 <= wheel_q;
		end
	end

	// Power is the magnitude times 255, shifted down and truncated toward zero.
	always_comb begin
		neg    = val_s1 < 0;
		mag    = neg ? ValW'(-val_s1) : ValW'(val_s1);
		prod   = (ProdW'(mag) << 8) - ProdW'(mag);
		scaled = prod >> FRAC_BITS;
		if (neg) begin
			if (scaled > ProdW'(POWER_NEG_LIM)) begin
				power_c = -POWER_W'(POWER_NEG_LIM);
			end else begin
				power_c = -$signed(POWER_W'(scaled));
			end
		end else begin
			if (scaled > ProdW'(POWER_POS_LIM)) begin
				power_c = POWER_W'(POWER_POS_LIM);
			end else begin
				power_c = $signed(POWER_W'(scaled));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			node_id_q <= NODE_IDS[wheel_s1];
			power_q   <= power_c;
			brake_q   <= (WHEEL_ROWS[wheel_s1] != ROW_MIDDLE) && (val_s1 == '0);
			last_q    <= (wheel_s1 == WHEEL_LAST);
		end
	end

	assign wheel.valid       = out_valid_q;
	assign wheel.node_id     = node_id_q;
	assign wheel.wheel_power = power_q;
	assign wheel.brake       = brake_q;
	assign wheel.last        = last_q;

endmodule

>>> sv/six_wheel_skid_steer_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_wheel_skid_steer_mixer: velocity command to six wheel commands
// A command passes through the queue, the first stage and the output register.
// Throughput: one wheel command per cycle while the wheel side does not stall;
// the single wheel stage that walks the six wheels sets this rate.
// A two-entry queue lets the next command be taken while one is being sent.
// Reset clears the queue and pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module six_wheel_skid_steer_mixer #(
	parameter int FRAC_BITS   = smx_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = smx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	smx_vel_if.sink                        cmd,
	smx_whl_if.source                      wheel,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [smx_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [smx_pkg::APB_DATA_W-1:0] pwdata,
	output logic [smx_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import smx_pkg::*;

	localparam int SideW  = FRAC_BITS + 2;
	localparam int EntryW = 2 * SideW + 1;

	smx_cfg_t          cfg;
	logic              wr_valid;
	logic              wr_ready;
	logic [EntryW-1:0] wr_data;
	logic              q_valid;
	logic              q_pop;
	logic [EntryW-1:0] q_data;

	smx_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smx_front #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (SideW)
	) u_front (
		.cmd      (cmd),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data)
	);

	smx_queue #(
		.WIDTH (EntryW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_data)
	);

	smx_back #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (SideW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.wheel   (wheel)
	);

endmodule

>>> sv/smx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_checker: port-level checks of the mixer
// Watches the wheel command channel and is bound to the top level.
// ----------------------------------------------------------------------------
module smx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        whl_valid,
	input logic        whl_ready,
	input logic [5:0]  whl_node_id,
	input logic [10:0] whl_power,
	input logic        whl_brake,
	input logic        whl_last
);

	// A stalled wheel command stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		whl_valid && !whl_ready |=> whl_valid && $stable(whl_node_id))
		else $error("wheel command dropped while stalled");

	// The run ends exactly on the right rear wheel.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		whl_valid |-> (whl_last == (whl_node_id == 6'h32)))
		else $error("last flag does not match the right rear wheel");

	// Middle wheels never brake.
	a_mid_brake: assert property (@(posedge clk) disable iff (!arst_n)
		whl_valid && (whl_node_id == 6'h21 || whl_node_id == 6'h22) |-> !whl_brake)
		else $error("middle wheel reports brake");

	// A braking wheel has zero value and therefore zero power.
	a_brake_power: assert property (@(posedge clk) disable iff (!arst_n)
		whl_valid && whl_brake |-> whl_power == 11'd0)
		else $error("brake set with nonzero power");

endmodule

bind six_wheel_skid_steer_mixer smx_checker u_smx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.whl_valid   (wheel.valid),
	.whl_ready   (wheel.ready),
	.whl_node_id (wheel.node_id),
	.whl_power   (wheel.wheel_power),
	.whl_brake   (wheel.brake),
	.whl_last    (wheel.last)
);

>>> verif/six_wheel_skid_steer_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_wheel_skid_steer_mixer_tb: self-checking bench of the skid steer mixer
// Velocity commands go in over the command channel and every wheel command
// that comes out is compared with a local prediction of the six wheel values
// for the drive mode and offsets that were written over the register port.
// The sender runs in random bursts and the wheel side stalls on its own
// rotating pattern. Directed vectors come first, then random phases.
// ----------------------------------------------------------------------------
module six_wheel_skid_steer_mixer_tb;

	import smx_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int UNIT        = 1 << FRAC;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

	localparam int MIDDLE_OFFSET_DEFAULT  = 410;
	localparam int STANDING_SPEED_DEFAULT = 819;
	localparam int FRONT_BOOST_DEFAULT    = 1229;

	typedef struct {
		logic [5:0]         node_id;
		logic signed [10:0] wheel_power;
		logic               brake;
		logic               last;
	} wheel_cmd_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	smx_vel_if cmd_if ();
	smx_whl_if whl_if ();

	six_wheel_skid_steer_mixer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.wheel   (whl_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register copy that the prediction works from.
	logic [2:0] mode_q;
	int         mid_offset_q;
	int         standing_q;
	int         boost_q;

	wheel_cmd_t expected_wheels[$];
	int         mismatch_cnt;
	int         cmd_cnt;
	int         wheel_cnt;
	int         reg_write_cnt;
	int         burst_left;
	int         cycle_cnt;

	logic [7:0] stall_mask = 8'hff;
	logic [2:0] stall_pos  = '0;
	int         stall_age  = 0;
	logic       stall_free = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic int clamp_unit(int v);
		if (v > UNIT)
			return UNIT;
		if (v < -UNIT)
			return -UNIT;
		return v;
	endfunction

	function automatic logic signed [10:0] power_of(int v);
		int mag;
		int p;
		mag = (v < 0) ? -v : v;
		p = (mag * 255) >> FRAC;
		if (v < 0)
			p = -p;
		if (p > 1023)
			p = 1023;
		if (p < -1024)
			p = -1024;
		return p[10:0];
	endfunction

	function automatic void predict_wheels(logic signed [15:0] lin, logic signed [15:0] ang);
		int         left_val;
		int         right_val;
		int         s;
		int         vals[3];
		bit         mid_zero;
		wheel_cmd_t w;
		left_val = clamp_unit(int'(lin) - int'(ang));
		right_val = clamp_unit(int'(lin) + int'(ang));
		mid_zero = (left_val > 0 && right_val < 0) || (left_val < 0 && right_val > 0);
		for (int sd = 0; sd < 2; sd++) begin
			s = (sd == 0) ? left_val : right_val;
			case (mode_q)
				MODE_NORMAL:      vals = '{s, s, s};
				MODE_BOGIE_DRIVE: vals = '{s, s + mid_offset_q, s};
				MODE_BOGIE_STAND: vals = '{s, s + standing_q, -standing_q};
				MODE_CLIMB:       vals = '{s + boost_q, s, s};
				MODE_BOGIE_BOOST: vals = '{s + boost_q, s + standing_q, -standing_q};
				default:          vals = '{0, 0, 0};
			endcase
			if (mid_zero)
				vals[1] = 0;
			for (int row = 0; row < 3; row++) begin
				w.node_id     = 6'((row + 1) * 16 + sd + 1);
				w.wheel_power = power_of(vals[row]);
				// Middle wheels never brake, even when their value is zero.
				w.brake       = (row != 1) && (vals[row] == 0);
				w.last        = (sd == 1) && (row == 2);
				expected_wheels.push_back(w);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DRIVE_MODE:     mode_q = value[2:0];
			REG_MIDDLE_OFFSET:  mid_offset_q = int'($signed(value[14:0]));
			REG_STANDING_SPEED: standing_q = int'($signed(value[14:0]));
			REG_FRONT_BOOST:    boost_q = int'($signed(value[14:0]));
			default: ;
		endcase
		reg_write_cnt++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_velocity(input logic signed [15:0] lin, input logic signed [15:0] ang);
		@(negedge clk);
		cmd_if.valid         <= 1'b1;
		cmd_if.linear_speed  <= lin;
		cmd_if.angular_speed <= ang;
		do @(posedge clk); while (!cmd_if.ready);
		predict_wheels(lin, ang);
		cmd_cnt++;
	endtask

	task automatic hold_cmd(input int cycles);
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 10);
			hold_cmd($urandom_range(0, 6));
		end
	endtask

	// Registers may only change once every wheel command has been taken.
	task automatic wait_idle();
		hold_cmd(0);
		while (expected_wheels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(0, 7))
			0, 1, 2: return 16'($urandom);
			3, 4:    return 16'($urandom_range(0, 2 * UNIT) - UNIT);
			5:       return 16'($urandom_range(0, 64) - 32);
			6:       return ($urandom_range(0, 1) != 0) ? 16'(UNIT) : -16'(UNIT);
			default: return 16'sd0;
		endcase
	endfunction

	function automatic int pick_offset();
		case ($urandom_range(0, 7))
			0:       return -16384;
			1:       return 16383;
			2:       return -2 * UNIT;
			3:       return 2 * UNIT;
			4:       return 0;
			5:       return int'($urandom_range(0, 32767)) - 16384;
			default: return int'($urandom_range(0, 4 * UNIT)) - 2 * UNIT;
		endcase
	endfunction

	// The wheel side stalls on a rotating mask that is redrawn now and then.
	always @(negedge clk) begin
		if (stall_age == 0) begin
			stall_mask <= 8'($urandom);
			stall_free <= ($urandom_range(0, 3) == 0);
			stall_age  <= $urandom_range(20, 60);
		end else begin
			stall_age <= stall_age - 1;
		end
		stall_pos    <= stall_pos + 3'd1;
		whl_if.ready <= stall_free || stall_mask[stall_pos];
	end

	// ------------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		wheel_cmd_t exp_w;
		if (arst_n && whl_if.valid && whl_if.ready) begin
			wheel_cnt++;
			if (expected_wheels.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("[%0t] unexpected wheel transfer: node %h power %0d",
						$realtime, whl_if.node_id, whl_if.wheel_power);
			end else begin
				exp_w = expected_wheels.pop_front();
				if (whl_if.node_id !== exp_w.node_id
						|| whl_if.wheel_power !== exp_w.wheel_power
						|| whl_if.brake !== exp_w.brake || whl_if.last !== exp_w.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"[%0t] wheel mismatch: expected node %h power %0d ",
							"brake %b last %b, got node %h power %0d brake %b last %b"},
							$realtime, exp_w.node_id, exp_w.wheel_power, exp_w.brake,
							exp_w.last, whl_if.node_id, whl_if.wheel_power, whl_if.brake,
							whl_if.last);
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timed out after %0d cycles with %0d wheel commands outstanding.",
			cycle_cnt, expected_wheels.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes, opposite sides and tiny values under the reset registers.
	task automatic test_reset_mode_extremes();
		logic signed [15:0] lins[10] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
			16'sd32767, -16'sd32768, 16'sd16, -16'sd3000, -16'sd1};
		logic signed [15:0] angs[10] = '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
			16'sd32767, -16'sd32768, 16'sd0, 16'sd1000, 16'sd0};
		for (int i = 0; i < 10; i++)
			send_velocity(lins[i], angs[i]);
		wait_idle();
	endtask

	// One same-sign and one turning command in each mode but normal, the spare codes too.
	task automatic test_mode_walk();
		for (int m = MODE_BOGIE_DRIVE; m <= MODE_SPARE_LAST; m++) begin
			write_reg(REG_DRIVE_MODE, m);
			send_velocity(16'sd2048, 16'sd512);
			send_velocity(16'sd0, 16'sd1500);
			wait_idle();
		end
	endtask

	// Offsets beyond their usual range drive the power into its limits.
	task automatic test_power_limits();
		write_reg(REG_DRIVE_MODE, MODE_BOGIE_BOOST);
		write_reg(REG_FRONT_BOOST, 16383);
		write_reg(REG_STANDING_SPEED, -16384);
		send_velocity(16'sd32767, 16'sd0);
		wait_idle();
		write_reg(REG_FRONT_BOOST, -16384);
		write_reg(REG_STANDING_SPEED, 16383);
		write_reg(REG_MIDDLE_OFFSET, -16384);
		send_velocity(-16'sd32768, 16'sd0);
		wait_idle();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			write_reg(REG_DRIVE_MODE, (phase + 4) % 8);
			write_reg(REG_MIDDLE_OFFSET, pick_offset());
			write_reg(REG_STANDING_SPEED, pick_offset());
			write_reg(REG_FRONT_BOOST, pick_offset());
			for (int n = 0; n < 10; n++) begin
				// Let the pipeline run dry once in the middle of a burst.
				if (phase == 3 && n == 6)
					wait_idle();
				send_velocity(pick_speed(), pick_speed());
				pace_sender();
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		cmd_if.valid         = 1'b0;
		cmd_if.linear_speed  = '0;
		cmd_if.angular_speed = '0;
		whl_if.ready         = 1'b0;
		mode_q               = MODE_NORMAL;
		mid_offset_q         = MIDDLE_OFFSET_DEFAULT;
		standing_q           = STANDING_SPEED_DEFAULT;
		boost_q              = FRONT_BOOST_DEFAULT;
		mismatch_cnt         = 0;
		cmd_cnt              = 0;
		wheel_cnt            = 0;
		reg_write_cnt        = 0;
		burst_left           = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_mode_extremes();
		test_mode_walk();
		test_power_limits();
		test_random_phases();

		repeat (16) @(posedge clk);
		$display("Run covered %0d velocity commands, %0d wheel transfers and %0d register writes",
			cmd_cnt, wheel_cnt, reg_write_cnt);
		$display("across all eight drive mode codes; %0d mismatches.", mismatch_cnt);
		if (mismatch_cnt == 0 && expected_wheels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
